// ===== hw/rtl/tcpm_pkg.sv =====
// Shared types and constants for the TCP header rule matcher.
package tcpm_pkg;

  // Header layout of a TCP segment.
  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned SRC_HI_BYTE = 0;
  localparam int unsigned SRC_LO_BYTE = 1;
  localparam int unsigned DST_HI_BYTE = 2;
  localparam int unsigned DST_LO_BYTE = 3;
  localparam int unsigned DOFF_BYTE   = 12;
  localparam int unsigned FLAG_BYTE   = 13;

  // Byte positions saturate at this value.
  localparam int unsigned POS_MAX = 127;
  localparam int unsigned POS_W   = 7;

  // Option kinds below this value take a single byte.
  localparam int unsigned OPT_SINGLE_LIMIT = 2;

  // Width of the configuration write data (the widest register).
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SRC_PORT_MIN = 3'd0,
    CFG_SRC_PORT_MAX = 3'd1,
    CFG_DST_PORT_MIN = 3'd2,
    CFG_DST_PORT_MAX = 3'd3,
    CFG_FLAG_MASK    = 3'd4,
    CFG_FLAG_COMPARE = 3'd5,
    CFG_OPTION_KIND  = 3'd6,
    CFG_INVERT_BITS  = 3'd7
  } cfg_reg_e;

  // Bit positions inside invert_bits.
  localparam int unsigned INV_SRC  = 0;
  localparam int unsigned INV_DST  = 1;
  localparam int unsigned INV_FLAG = 2;
  localparam int unsigned INV_OPT  = 3;

  // Rule configuration as seen by the parser and the verdict logic.
  typedef struct packed {
    logic [15:0] src_port_min;
    logic [15:0] src_port_max;
    logic [15:0] dst_port_min;
    logic [15:0] dst_port_max;
    logic [7:0]  flag_mask;
    logic [7:0]  flag_compare;
    logic [7:0]  option_kind;
    logic [3:0]  invert_bits;
  } cfg_t;

  // Everything the verdict needs about one finished segment.
  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flags;
    logic [3:0]  data_offset;
    logic        option_seen;
    logic [12:0] frag_offset;
    logic [15:0] seg_length;
  } seg_rec_t;

endpackage

// ===== hw/rtl/tcpm_if.sv =====
// Stream interfaces for segment bytes in and verdicts out.
interface tcpm_seg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seg_byte;
  logic        first_byte;
  logic        last_byte;
  logic [12:0] frag_offset;
  logic [15:0] seg_length;

  modport source(output valid, output seg_byte, output first_byte, output last_byte,
                 output frag_offset, output seg_length, input ready);
  modport sink(input valid, input seg_byte, input first_byte, input last_byte,
               input frag_offset, input seg_length, output ready);
endinterface

interface tcpm_verdict_if;
  logic valid;
  logic ready;
  logic matched;
  logic hot_drop;

  modport source(output valid, output matched, output hot_drop, input ready);
  modport sink(input valid, input matched, input hot_drop, output ready);
endinterface

// ===== hw/rtl/tcpm_front.sv =====
// Byte parser: captures header fields, walks options, emits one record per segment.
module tcpm_front
  import tcpm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  tcpm_seg_if.sink       seg_in,
  input  logic [7:0]     option_kind,
  input  logic           rec_full,
  output logic           rec_push,
  output seg_rec_t       rec
);

  // Segment state.
  logic [POS_W-1:0] byte_position;
  logic [15:0]      captured_src_port;
  logic [15:0]      captured_dst_port;
  logic [7:0]       captured_flags;
  logic [3:0]       captured_data_offset;
  logic [POS_W-1:0] next_option_position;
  logic             awaiting_option_length;
  logic             option_seen;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      captured_src_port_next;
  logic [15:0]      captured_dst_port_next;
  logic [7:0]       captured_flags_next;
  logic [3:0]       captured_data_offset_next;
  logic [POS_W-1:0] next_option_position_next;
  logic             awaiting_option_length_next;
  logic             option_seen_next;

  logic             accept;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] hdr_len;
  logic [7:0]       step;
  logic [8:0]       opt_sum;
  logic [POS_W:0]   pos_inc;
  logic [7:0]       b;

  // A byte is taken whenever the record queue has room.
  assign seg_in.ready = !rec_full;
  assign accept       = seg_in.valid && seg_in.ready;
  assign b            = seg_in.seg_byte;

  // Work out the state after this byte; a first byte starts from a clean segment.
  always_comb begin
    if (seg_in.first_byte) begin
      pos                         = '0;
      captured_src_port_next      = '0;
      captured_dst_port_next      = '0;
      captured_flags_next         = '0;
      captured_data_offset_next   = '0;
      next_option_position_next   = POS_W'(HDR_BYTES);
      awaiting_option_length_next = 1'b0;
      option_seen_next            = 1'b0;
    end else begin
      pos                         = byte_position;
      captured_src_port_next      = captured_src_port;
      captured_dst_port_next      = captured_dst_port;
      captured_flags_next         = captured_flags;
      captured_data_offset_next   = captured_data_offset;
      next_option_position_next   = next_option_position;
      awaiting_option_length_next = awaiting_option_length;
      option_seen_next            = option_seen;
    end

    // Header length uses the data offset as it stood before this byte.
    hdr_len = {1'b0, captured_data_offset_next, 2'b00};

    // Field capture by position.
    case (pos)
      POS_W'(SRC_HI_BYTE): captured_src_port_next[15:8] = b;
      POS_W'(SRC_LO_BYTE): captured_src_port_next[7:0]  = b;
      POS_W'(DST_HI_BYTE): captured_dst_port_next[15:8] = b;
      POS_W'(DST_LO_BYTE): captured_dst_port_next[7:0]  = b;
      POS_W'(DOFF_BYTE):   captured_data_offset_next    = b[7:4];
      POS_W'(FLAG_BYTE):   captured_flags_next          = b;
      default: ;
    endcase

    // Option walk past the fixed header. A zero length counts as one.
    step    = (b == 8'd0) ? 8'd1 : b;
    opt_sum = {2'b00, next_option_position_next} + {1'b0, step};
    pos_inc = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};
    if (pos >= POS_W'(HDR_BYTES)) begin
      if (awaiting_option_length_next) begin
        next_option_position_next   = (opt_sum > 9'(POS_MAX)) ? POS_W'(POS_MAX)
                                                              : opt_sum[POS_W-1:0];
        awaiting_option_length_next = 1'b0;
      end else if (pos == next_option_position_next && pos < hdr_len) begin
        if (b == option_kind) begin
          option_seen_next = 1'b1;
        end
        if (b < 8'(OPT_SINGLE_LIMIT)) begin
          next_option_position_next = (pos_inc > (POS_W+1)'(POS_MAX)) ? POS_W'(POS_MAX)
                                                                     : pos_inc[POS_W-1:0];
        end else begin
          awaiting_option_length_next = 1'b1;
        end
      end
    end

    byte_position_next = (pos_inc > (POS_W+1)'(POS_MAX)) ? POS_W'(POS_MAX)
                                                         : pos_inc[POS_W-1:0];
  end

  // The record for the verdict carries the state after the last byte.
  assign rec_push         = accept && seg_in.last_byte;
  assign rec.src_port     = captured_src_port_next;
  assign rec.dst_port     = captured_dst_port_next;
  assign rec.flags        = captured_flags_next;
  assign rec.data_offset  = captured_data_offset_next;
  assign rec.option_seen  = option_seen_next;
  assign rec.frag_offset  = seg_in.frag_offset;
  assign rec.seg_length   = seg_in.seg_length;

  // Segment state register; cleared after each last byte.
  always_ff @(posedge clk) begin
    if (rst || (accept && seg_in.last_byte)) begin
      byte_position          <= '0;
      captured_src_port      <= '0;
      captured_dst_port      <= '0;
      captured_flags         <= '0;
      captured_data_offset   <= '0;
      next_option_position   <= POS_W'(HDR_BYTES);
      awaiting_option_length <= 1'b0;
      option_seen            <= 1'b0;
    end else if (accept) begin
      byte_position          <= byte_position_next;
      captured_src_port      <= captured_src_port_next;
      captured_dst_port      <= captured_dst_port_next;
      captured_flags         <= captured_flags_next;
      captured_data_offset   <= captured_data_offset_next;
      next_option_position   <= next_option_position_next;
      awaiting_option_length <= awaiting_option_length_next;
      option_seen            <= option_seen_next;
    end
  end

  // A finished segment leaves the parser in its clean starting state.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    rec_push |=> (byte_position == '0 && next_option_position == POS_W'(HDR_BYTES)
                  && !awaiting_option_length && !option_seen))
    else $error("parser state not cleared after last byte");

  // The option walk never points back into the fixed header.
  a_opt_pos_floor: assert property (@(posedge clk) disable iff (rst)
    next_option_position >= POS_W'(HDR_BYTES))
    else $error("option position fell below header end");

endmodule

// ===== hw/rtl/tcpm_queue.sv =====
// Small record queue between the byte parser and the verdict stage.
module tcpm_queue
  import tcpm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  seg_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output seg_rec_t head_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  seg_rec_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // A push with no pop always grows the fill count by one.
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not grow on push");

endmodule

// ===== hw/rtl/tcpm_back.sv =====
// Verdict stage: applies the rule to a segment record and holds the result.
module tcpm_back
  import tcpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          rec_valid,
  input  seg_rec_t      rec,
  output logic          rec_pop,
  tcpm_verdict_if.source verdict_out
);

  logic       out_valid;
  logic       matched;
  logic       hot_drop;
  logic       matched_next;
  logic       hot_drop_next;
  logic       src_ok;
  logic       dst_ok;
  logic       flag_ok;
  logic [5:0] hdr_len;

  // Take the next record when the output register is free or being emptied.
  assign rec_pop = rec_valid && (!out_valid || verdict_out.ready);

  // Rule evaluation in the documented order.
  always_comb begin
    src_ok  = ((rec.src_port >= cfg.src_port_min) && (rec.src_port <= cfg.src_port_max))
              ^ cfg.invert_bits[INV_SRC];
    dst_ok  = ((rec.dst_port >= cfg.dst_port_min) && (rec.dst_port <= cfg.dst_port_max))
              ^ cfg.invert_bits[INV_DST];
    flag_ok = ((rec.flags & cfg.flag_mask) == cfg.flag_compare) ^ cfg.invert_bits[INV_FLAG];
    hdr_len = {rec.data_offset, 2'b00};
    matched_next  = 1'b0;
    hot_drop_next = 1'b0;
    if (rec.frag_offset == 13'd1) begin
      hot_drop_next = 1'b1;
    end else if (rec.frag_offset == 13'd0 && rec.seg_length < 16'(HDR_BYTES)) begin
      hot_drop_next = 1'b1;
    end else if (rec.frag_offset == 13'd0) begin
      matched_next = src_ok && dst_ok && flag_ok;
      if (matched_next && cfg.option_kind != 8'd0) begin
        if (hdr_len < 6'(HDR_BYTES) || {10'd0, hdr_len} > rec.seg_length) begin
          hot_drop_next = 1'b1;
          matched_next  = 1'b0;
        end else begin
          matched_next = rec.option_seen ^ cfg.invert_bits[INV_OPT];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (verdict_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      matched  <= matched_next;
      hot_drop <= hot_drop_next;
    end
  end

  assign verdict_out.valid    = out_valid;
  assign verdict_out.matched  = matched;
  assign verdict_out.hot_drop = hot_drop;

  // A segment is never both matched and dropped.
  a_verdict_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && hot_drop))
    else $error("verdict both matched and hot drop");

endmodule

// ===== hw/rtl/tcp_header_rule_match.sv =====
// TCP header rule matcher: top level with configuration registers.
// Segment bytes stream in one per clock, back to back, while the record queue
// has room; the parser updates its state on each accepted byte, so the
// sustained rate is one byte per cycle until the queue fills. On the transfer
// of a last byte a segment record enters a short queue; the verdict stage
// pops it, evaluates the rule on that record and registers the verdict
// (matched, hot_drop) in its output register. The queue lets the byte input
// keep flowing while a verdict waits for its transfer, until the queue fills.
// Configuration registers may be written only while no segment or verdict is
// in flight.
module tcp_header_rule_match
  import tcpm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tcpm_seg_if.sink               seg_in,
  tcpm_verdict_if.source         verdict_out
);

  cfg_t     cfg;
  seg_rec_t push_rec;
  seg_rec_t head_rec;
  logic     rec_push;
  logic     rec_full;
  logic     rec_pop;
  logic     head_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_port_min <= 16'h0000;
      cfg.src_port_max <= 16'hFFFF;
      cfg.dst_port_min <= 16'h0000;
      cfg.dst_port_max <= 16'hFFFF;
      cfg.flag_mask    <= 8'h00;
      cfg.flag_compare <= 8'h00;
      cfg.option_kind  <= 8'h00;
      cfg.invert_bits  <= 4'h0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_SRC_PORT_MIN: cfg.src_port_min <= cfg_data;
        CFG_SRC_PORT_MAX: cfg.src_port_max <= cfg_data;
        CFG_DST_PORT_MIN: cfg.dst_port_min <= cfg_data;
        CFG_DST_PORT_MAX: cfg.dst_port_max <= cfg_data;
        CFG_FLAG_MASK:    cfg.flag_mask    <= cfg_data[7:0];
        CFG_FLAG_COMPARE: cfg.flag_compare <= cfg_data[7:0];
        CFG_OPTION_KIND:  cfg.option_kind  <= cfg_data[7:0];
        CFG_INVERT_BITS:  cfg.invert_bits  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Byte parser.
  tcpm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .seg_in      (seg_in),
    .option_kind (cfg.option_kind),
    .rec_full    (rec_full),
    .rec_push    (rec_push),
    .rec         (push_rec)
  );

  // Record queue.
  tcpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rec_push),
    .push_rec   (push_rec),
    .full       (rec_full),
    .pop        (rec_pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // Verdict stage.
  tcpm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .rec_valid   (head_valid),
    .rec         (head_rec),
    .rec_pop     (rec_pop),
    .verdict_out (verdict_out)
  );

endmodule

// ===== tb/tcp_header_rule_match_tb.sv =====
// Self-checking testbench for the TCP header rule matcher.
`timescale 1ns / 100ps

module tcp_header_rule_match_tb
  import tcpm_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned N_SETTINGS     = 8;
  localparam int unsigned SETTING_ITEMS  = 165;

  localparam logic [7:0] OPT_END = 8'd0;
  localparam logic [7:0] OPT_NOP = 8'd1;
  localparam logic [7:0] OPT_MSS = 8'd2;

  typedef struct packed {
    bit matched;
    bit hot_drop;
  } verdict_t;

  // Tracks the segment being parsed and holds the verdicts still owed by the block.
  class verdict_board;
    cfg_t        rules;
    int unsigned pos;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flags;
    logic [3:0]  data_offset;
    int unsigned next_opt;
    bit          awaiting_len;
    bit          opt_seen;
    verdict_t    pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned match_count;
    int unsigned hot_drops;

    function new();
      rules = '0;
      rules.src_port_max = 16'hFFFF;
      rules.dst_port_max = 16'hFFFF;
      clear_segment();
    endfunction

    function void clear_segment();
      pos          = 0;
      src_port     = '0;
      dst_port     = '0;
      flags        = '0;
      data_offset  = '0;
      next_opt     = HDR_BYTES;
      awaiting_len = 1'b0;
      opt_seen     = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        CFG_SRC_PORT_MIN: rules.src_port_min = data;
        CFG_SRC_PORT_MAX: rules.src_port_max = data;
        CFG_DST_PORT_MIN: rules.dst_port_min = data;
        CFG_DST_PORT_MAX: rules.dst_port_max = data;
        CFG_FLAG_MASK:    rules.flag_mask    = data[7:0];
        CFG_FLAG_COMPARE: rules.flag_compare = data[7:0];
        CFG_OPTION_KIND:  rules.option_kind  = data[7:0];
        CFG_INVERT_BITS:  rules.invert_bits  = data[3:0];
        default: ;
      endcase
    endfunction

    // An empty range (min above max) never matches before the invert.
    function bit port_ok(logic [15:0] lo, logic [15:0] hi, logic [15:0] v, bit inv);
      return ((v >= lo) && (v <= hi)) != inv;
    endfunction

    // One accepted segment byte; a last byte queues the verdict it produces.
    function void note_byte(logic [7:0] b, logic first, logic last, logic [12:0] frag,
                            logic [15:0] len);
      int unsigned p;
      int unsigned hdr_len;
      int unsigned nxt;
      verdict_t    v;
      if (first) clear_segment();
      p = pos;
      hdr_len = data_offset * 4;
      case (p)
        SRC_HI_BYTE: src_port[15:8] = b;
        SRC_LO_BYTE: src_port[7:0]  = b;
        DST_HI_BYTE: dst_port[15:8] = b;
        DST_LO_BYTE: dst_port[7:0]  = b;
        DOFF_BYTE:   data_offset    = b[7:4];
        FLAG_BYTE:   flags          = b;
        default: ;
      endcase
      // Option walk: a length byte moves the next kind position, zero counts as one.
      if (p >= HDR_BYTES) begin
        if (awaiting_len) begin
          nxt = next_opt + ((b != 8'd0) ? b : 1);
          next_opt = (nxt > POS_MAX) ? POS_MAX : nxt;
          awaiting_len = 1'b0;
        end else if (p == next_opt && p < hdr_len) begin
          if (b == rules.option_kind) opt_seen = 1'b1;
          if (b < OPT_SINGLE_LIMIT) begin
            next_opt = (p + 1 > POS_MAX) ? POS_MAX : p + 1;
          end else begin
            awaiting_len = 1'b1;
          end
        end
      end
      pos = (p + 1 > POS_MAX) ? POS_MAX : p + 1;
      if (!last) return;

      // Fragment and length screens come first, then the rule tests in order.
      v = '0;
      if (frag == 13'd1) begin
        v.hot_drop = 1'b1;
      end else if (frag == 13'd0 && len < HDR_BYTES) begin
        v.hot_drop = 1'b1;
      end else if (frag == 13'd0) begin
        v.matched = port_ok(rules.src_port_min, rules.src_port_max, src_port,
                            rules.invert_bits[INV_SRC])
                 && port_ok(rules.dst_port_min, rules.dst_port_max, dst_port,
                            rules.invert_bits[INV_DST])
                 && (((flags & rules.flag_mask) == rules.flag_compare)
                     != rules.invert_bits[INV_FLAG]);
        if (v.matched && rules.option_kind != 8'd0) begin
          hdr_len = data_offset * 4;
          if (hdr_len < HDR_BYTES || hdr_len > len) begin
            v.hot_drop = 1'b1;
            v.matched  = 1'b0;
          end else begin
            v.matched = opt_seen != rules.invert_bits[INV_OPT];
          end
        end
      end
      pending.push_back(v);
      clear_segment();
    endfunction

    function void check_verdict(logic m, logic h);
      verdict_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: verdict with none pending: matched=%b hot_drop=%b", $realtime, m, h);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.matched) match_count++;
      if (want.hot_drop) hot_drops++;
      if (m !== want.matched || h !== want.hot_drop) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: verdict %0d expected matched=%b hot_drop=%b, got matched=%b hot_drop=%b",
                   $realtime, checked, want.matched, want.hot_drop, m, h);
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           cfg_we;
  cfg_reg_e       cfg_index;
  logic [15:0]    cfg_data;
  tcpm_seg_if     seg_bus();
  tcpm_verdict_if verdict_bus();

  verdict_board board = new();
  int unsigned  items_sent;
  int unsigned  gap_pct;
  bit           no_idle;
  int unsigned  idle_cycles;

  tcp_header_rule_match u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .seg_in      (seg_bus),
    .verdict_out (verdict_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both channels; every transfer feeds the predictor or the checker.
  always @(posedge clk) begin
    if (!rst) begin
      if (seg_bus.valid && seg_bus.ready)
        board.note_byte(seg_bus.seg_byte, seg_bus.first_byte, seg_bus.last_byte,
                        seg_bus.frag_offset, seg_bus.seg_length);
      if (verdict_bus.valid && verdict_bus.ready)
        board.check_verdict(verdict_bus.matched, verdict_bus.hot_drop);
    end
  end

  // Stop the run once neither channel has moved for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (seg_bus.valid && seg_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Verdict receiver: ready drops in random bursts.
  initial begin
    verdict_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
        verdict_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      verdict_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_item(logic [7:0] b, logic first, logic last, logic [12:0] frag,
                           logic [15:0] len);
    seg_bus.valid       <= 1'b1;
    seg_bus.seg_byte    <= b;
    seg_bus.first_byte  <= first;
    seg_bus.last_byte   <= last;
    seg_bus.frag_offset <= frag;
    seg_bus.seg_length  <= len;
    @(posedge clk);
    while (!seg_bus.ready) @(posedge clk);
    items_sent++;
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      seg_bus.valid       <= 1'b0;
      seg_bus.seg_byte    <= 8'($urandom);
      seg_bus.first_byte  <= 1'($urandom);
      seg_bus.last_byte   <= 1'($urandom);
      seg_bus.frag_offset <= 13'($urandom);
      seg_bus.seg_length  <= 16'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Narrow registers get junk in their upper data bits, which must be dropped.
  task automatic program_rules(cfg_t r);
    write_reg(CFG_SRC_PORT_MIN, r.src_port_min);
    write_reg(CFG_SRC_PORT_MAX, r.src_port_max);
    write_reg(CFG_DST_PORT_MIN, r.dst_port_min);
    write_reg(CFG_DST_PORT_MAX, r.dst_port_max);
    write_reg(CFG_FLAG_MASK, {8'($urandom), r.flag_mask});
    write_reg(CFG_FLAG_COMPARE, {8'($urandom), r.flag_compare});
    write_reg(CFG_OPTION_KIND, {8'($urandom), r.option_kind});
    write_reg(CFG_INVERT_BITS, {12'($urandom), r.invert_bits});
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Rule settings: open ranges, single-value extremes, empty ranges, then random.
  function automatic cfg_t make_rules(int unsigned p);
    cfg_t        r;
    int unsigned lo;
    logic [15:0] tmp;
    r = '0;
    r.src_port_max = 16'hFFFF;
    r.dst_port_max = 16'hFFFF;
    r.option_kind  = OPT_MSS;
    case (p)
      0: ;
      1: begin
        r.src_port_min = 16'hFFFF;
        r.dst_port_max = 16'h0000;
        r.flag_mask    = 8'hFF;
        r.flag_compare = 8'($urandom);
        r.option_kind  = 8'hFF;
        r.invert_bits  = 4'hF;
      end
      2: begin
        r.src_port_min = 16'd40000;
        r.src_port_max = 16'd1000;
        r.dst_port_min = 16'hFFFF;
        r.dst_port_max = 16'h0000;
        r.flag_mask    = 8'($urandom);
        r.flag_compare = r.flag_mask & 8'($urandom);
        r.option_kind  = OPT_END;
        r.invert_bits  = 4'h3;
      end
      default: begin
        lo = $urandom_range(0, 65535);
        r.src_port_min = 16'(lo);
        r.src_port_max = 16'((lo + 6000 > 65535) ? 65535 : lo + $urandom_range(0, 6000));
        lo = $urandom_range(0, 65535);
        r.dst_port_min = 16'(lo);
        r.dst_port_max = 16'((lo + 6000 > 65535) ? 65535 : lo + $urandom_range(0, 6000));
        if ($urandom_range(0, 9) == 0) begin
          tmp = r.src_port_min;
          r.src_port_min = r.src_port_max;
          r.src_port_max = tmp;
        end
        r.flag_mask    = 8'($urandom);
        r.flag_compare = ($urandom_range(0, 4) != 0) ? (r.flag_mask & 8'($urandom))
                                                     : 8'($urandom);
        case ($urandom_range(0, 3))
          0: r.option_kind = OPT_END;
          1: r.option_kind = OPT_NOP;
          2: r.option_kind = 8'($urandom_range(2, 8));
          default: r.option_kind = 8'($urandom);
        endcase
        r.invert_bits = 4'($urandom);
      end
    endcase
    return r;
  endfunction

  // Ports near the edges of the configured range, or anywhere.
  function automatic logic [15:0] pick_port(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return lo;
      2: return hi;
      3: return lo - 16'd1;
      4: return hi + 16'd1;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // One segment: mostly well-formed headers with option lists, plus truncated
  // segments, noise, missing start marks and restarts partway through.
  task automatic run_segment();
    logic [7:0]  body[$];
    bit          starts[$];
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] len;
    logic [12:0] frag;
    logic [7:0]  kind;
    logic [7:0]  olen;
    logic [7:0]  flg;
    int unsigned doff;
    int unsigned hdr_len;
    int unsigned style;
    int unsigned n;
    int unsigned r;
    style = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: doff = $urandom_range(0, 4);
      1: doff = $urandom_range(9, 15);
      default: doff = $urandom_range(5, 8);
    endcase
    hdr_len = doff * 4;
    sp = pick_port(board.rules.src_port_min, board.rules.src_port_max);
    dp = pick_port(board.rules.dst_port_min, board.rules.dst_port_max);
    if ($urandom_range(0, 9) < 6)
      flg = (8'($urandom) & ~board.rules.flag_mask)
          | (board.rules.flag_compare & board.rules.flag_mask);
    else
      flg = 8'($urandom);

    body = {sp[15:8], sp[7:0], dp[15:8], dp[7:0]};
    repeat (8) body.push_back(8'($urandom));
    body.push_back({doff[3:0], 4'($urandom)});
    body.push_back(flg);
    repeat (6) body.push_back(8'($urandom));
    while (body.size() < hdr_len) begin
      case ($urandom_range(0, 9))
        0, 1, 2: kind = OPT_NOP;
        3:       kind = OPT_END;
        4, 5, 6: kind = board.rules.option_kind;
        7, 8:    kind = 8'($urandom_range(2, 8));
        default: kind = 8'($urandom);
      endcase
      body.push_back(kind);
      if (kind >= OPT_SINGLE_LIMIT) begin
        r = $urandom_range(0, 9);
        olen = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom) : 8'($urandom_range(2, 10));
        body.push_back(olen);
        n = (olen > 8'd2) ? olen - 2 : 0;
        repeat ((n > 10) ? 10 : n) body.push_back(8'($urandom));
      end
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(70, 130) : $urandom_range(0, 8);
    repeat (n) body.push_back(8'($urandom));

    if (style < 15) begin
      body.delete();
      repeat ($urandom_range(1, 40)) body.push_back(8'($urandom));
    end else if (style < 30) begin
      n = $urandom_range(1, body.size());
      while (body.size() > n) void'(body.pop_back());
    end
    foreach (body[i])
      starts.push_back((i == 0) ? ($urandom_range(0, 9) != 0)
                                : (style < 15 && $urandom_range(0, 29) == 0));
    if (style >= 95) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        body.push_front(8'($urandom));
        starts.push_front(1'b0);
      end
      starts[0] = 1'b1;
      starts[n] = 1'b1;
    end

    r = $urandom_range(0, 99);
    if (r < 85)      frag = 13'd0;
    else if (r < 90) frag = 13'd1;
    else             frag = 13'($urandom_range(2, 8191));
    case ($urandom_range(0, 9))
      7:       len = 16'($urandom);
      8:       len = 16'($urandom_range(0, HDR_BYTES - 1));
      9:       len = 16'((hdr_len > 0) ? hdr_len - 1 : 0);
      default: len = 16'(body.size());
    endcase
    foreach (body[i]) send_item(body[i], starts[i], i == body.size() - 1, frag, len);
  endtask

  // Short directed segments at the reset rule.
  task automatic directed_part();
    logic [7:0] hdr20[20] = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
                              8'h9A, 8'hBC, 8'hDE, 8'hF0, 8'h5F, 8'hFF, 8'h00, 8'h40,
                              8'hA5, 8'h5A, 8'h00, 8'h00};
    // Tiny unfragmented, offset one, other fragment, then a segment with no start mark.
    send_item(8'hFF, 1'b1, 1'b1, 13'd0, 16'd0);
    send_item(8'h00, 1'b1, 1'b1, 13'd1, 16'hFFFF);
    send_item(8'hFF, 1'b1, 1'b1, 13'h1FFF, 16'hFFFF);
    send_item(8'h80, 1'b0, 1'b1, 13'd0, 16'd20);
    // A bare minimum header with extreme ports and every flag set.
    foreach (hdr20[i]) send_item(hdr20[i], i == 0, i == 19, 13'd0, 16'd20);
    seg_bus.valid <= 1'b0;
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_SRC_PORT_MIN;
    cfg_data            <= '0;
    seg_bus.valid       <= 1'b0;
    seg_bus.seg_byte    <= '0;
    seg_bus.first_byte  <= 1'b0;
    seg_bus.last_byte   <= 1'b0;
    seg_bus.frag_offset <= '0;
    seg_bus.seg_length  <= '0;
    items_sent = 0;
    gap_pct    = 0;
    no_idle    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_part();
    wait_drain();

    for (int unsigned p = 0; p < N_SETTINGS; p++) begin
      int unsigned target;
      program_rules(make_rules(p));
      gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 12 : 35;
      no_idle = (p == N_SETTINGS - 1);
      target  = items_sent + SETTING_ITEMS;
      while (items_sent < target) run_segment();
      seg_bus.valid <= 1'b0;
      wait_drain();
    end

    $display("Run sent %0d segment bytes and checked %0d verdicts over %0d rule settings.",
             items_sent, board.checked, N_SETTINGS + 1);
    $display("Expected verdicts held %0d matches and %0d hot drops.",
             board.match_count, board.hot_drops);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad verdicts, %0d still pending", board.errors, board.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
